### src/indexed_priority_queue_assert.svh
// Assertion macros for the indexed priority queue
`ifndef INDEXED_PRIORITY_QUEUE_ASSERT_SVH
`define INDEXED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define IPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipq check failed");

// next-cycle implication
`define IPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipq check failed");

`endif

### src/ipq_pkg.sv
`default_nettype none
package ipq_pkg;
   localparam int ID_W   = 6;
   localparam int PRIO_W = 32;
   localparam int CNT_W  = 7;
   localparam int TYPE_W = 3;

   localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_RAISE  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_LOWER  = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_REMOVE = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_QUERY  = 3'd4;

   typedef struct packed {
      logic [ID_W-1:0]          id;
      logic signed [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic gt;
      logic eq;
   } cmp_type;
endpackage
`default_nettype wire

### src/indexed_priority_queue.sv
`default_nettype none
// Indexed priority queue: ids with signed Q16.16 priorities, held in
// descending order in a sorted store, with a per-id presence bit and
// priority copy.
// Request channel (req_*): valid/stall; one beat is one request (insert,
// raise, lower, remove highest, query). Response channel (rsp_*):
// valid/stall; exactly one beat per request, in request order.
// csr_wr_en/csr_wr_data write id_limit; write only while idle.
// Steps per request: a sorted-store step is a registered RAM read, then a
// compare and write, on the single store port. Query and rejected requests
// go straight from decide to finish. Insert moves each entry behind the new
// one back a place, from the tail. Remove highest reads the head, then
// shifts every entry forward. Raise/lower: find, close the gap and re-place.
// One request is handled at a time; the next is taken once the response
// is in the output register.
// A stalled response holds in the output register; the sequencer waits at
// its final step until the register frees.
// Reset (synchronous): presence map and count cleared, id_limit = 64.
module indexed_priority_queue #(
   parameter int MAX_IDS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [6:0]                        csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ipq_pkg::TYPE_W-1:0]        req_type,
   input  logic [ipq_pkg::ID_W-1:0]          req_item_id,
   input  logic signed [ipq_pkg::PRIO_W-1:0] req_new_priority,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_ok,
   output logic [ipq_pkg::ID_W-1:0]          rsp_out_id,
   output logic signed [ipq_pkg::PRIO_W-1:0] rsp_out_priority,
   output logic [ipq_pkg::CNT_W-1:0]         rsp_entry_count
);
   import ipq_pkg::*;

   // ids are 6 bits wide, so no more than 64 can ever be held
   localparam int IDN = (MAX_IDS < 64) ? MAX_IDS : 64;
   localparam int IDW = $clog2(IDN);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DECIDE   = 4'd1;
   localparam logic [3:0] ST_FIND_RD  = 4'd2;
   localparam logic [3:0] ST_FIND_USE = 4'd3;
   localparam logic [3:0] ST_SHL_RD   = 4'd4;
   localparam logic [3:0] ST_SHL_WR   = 4'd5;
   localparam logic [3:0] ST_INS_RD   = 4'd6;
   localparam logic [3:0] ST_INS_USE  = 4'd7;
   localparam logic [3:0] ST_HEAD     = 4'd8;
   localparam logic [3:0] ST_FIN      = 4'd9;

   logic [3:0]               state_ff, state_in;
   logic [TYPE_W-1:0]        kind_ff;
   logic [ID_W-1:0]          id_ff;
   logic signed [PRIO_W-1:0] np_ff;
   logic [CNT_W-1:0]         i_ff, i_in;
   logic [CNT_W-1:0]         held_ff, held_in;
   logic [6:0]               limit_ff;
   logic [IDN-1:0]           present_ff, present_in;
   logic                     res_ok_ff, res_ok_in;
   logic [ID_W-1:0]          res_id_ff, res_id_in;
   logic signed [PRIO_W-1:0] res_prio_ff, res_prio_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ok_ff;
   logic [ID_W-1:0]          rsp_id_ff;
   logic signed [PRIO_W-1:0] rsp_prio_ff;
   logic [CNT_W-1:0]         rsp_cnt_ff;

   logic                     accept;
   logic                     load_rsp;
   logic                     id_ok;
   logic                     pres;
   logic                     go;
   logic                     pred;

   // sorted store port
   logic                     st_we;
   logic [CNT_W-1:0]         st_waddr;
   entry_type                st_wdata;
   logic [CNT_W-1:0]         st_raddr;
   entry_type                st_rdata;
   // per-id priority copy
   logic                     ip_we;
   logic signed [PRIO_W-1:0] ip_rdata;
   // shared comparator
   logic signed [PRIO_W-1:0] cmp_a, cmp_b;
   cmp_type                  cmp;

   ipq_ram #(.WIDTH($bits(entry_type)), .DEPTH(IDN)) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr[IDW-1:0]),
      .wr_data (st_wdata),
      .rd_addr (st_raddr[IDW-1:0]),
      .rd_data (st_rdata)
   );

   ipq_ram #(.WIDTH(PRIO_W), .DEPTH(IDN)) u_id_prio (
      .clock   (clock),
      .wr_en   (ip_we),
      .wr_addr (id_ff[IDW-1:0]),
      .wr_data (np_ff),
      .rd_addr (req_item_id[IDW-1:0]),
      .rd_data (ip_rdata)
   );

   ipq_cmp u_cmp (
      .a   (cmp_a),
      .b   (cmp_b),
      .res (cmp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign load_rsp  = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);

   assign id_ok = ({1'b0, id_ff} < limit_ff) && (int'(id_ff) < MAX_IDS);
   assign pres  = present_ff[id_ff[IDW-1:0]];

   // decide compares new against the id's copy; placing compares the
   // store entry against the new priority
   assign cmp_a = (state_ff == ST_DECIDE) ? np_ff : st_rdata.prio;
   assign cmp_b = (state_ff == ST_DECIDE) ? ip_rdata : np_ff;

   assign go   = (kind_ff == REQ_RAISE) ? cmp.gt : (!cmp.gt && !cmp.eq);
   // lowered entries go behind equals, others ahead of them
   assign pred = (kind_ff == REQ_LOWER) ? (!cmp.gt && !cmp.eq) : !cmp.gt;

   always_comb begin
      case (state_ff)
         ST_DECIDE: st_raddr = '0;
         ST_SHL_RD: st_raddr = i_ff + 1'b1;
         ST_INS_RD: st_raddr = i_ff - 1'b1;
         default:   st_raddr = i_ff;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      held_in     = held_ff;
      present_in  = present_ff;
      res_ok_in   = res_ok_ff;
      res_id_in   = res_id_ff;
      res_prio_in = res_prio_ff;
      st_we       = 1'b0;
      st_waddr    = i_ff;
      st_wdata    = st_rdata;
      ip_we       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_ok_in   = 1'b0;
            res_id_in   = id_ff;
            res_prio_in = '0;
            state_in    = ST_FIN;
            case (kind_ff)
               REQ_INSERT: begin
                  if (id_ok && !pres && (held_ff < CNT_W'(IDN))) begin
                     present_in[id_ff[IDW-1:0]] = 1'b1;
                     ip_we     = 1'b1;
                     res_ok_in = 1'b1;
                     i_in      = held_ff;
                     state_in  = ST_INS_RD;
                  end
               end
               REQ_RAISE, REQ_LOWER: begin
                  if (id_ok && pres && go) begin
                     ip_we     = 1'b1;
                     res_ok_in = 1'b1;
                     i_in      = '0;
                     state_in  = ST_FIND_RD;
                  end
               end
               REQ_REMOVE: begin
                  res_id_in = '0;
                  if (held_ff != '0) begin
                     state_in = ST_HEAD;
                  end
               end
               REQ_QUERY: begin
                  if (id_ok && pres) begin
                     res_ok_in   = 1'b1;
                     res_prio_in = ip_rdata;
                  end
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_FIND_RD: begin
            state_in = ST_FIND_USE;
         end
         ST_FIND_USE: begin
            if (st_rdata.id == id_ff) begin
               state_in = ST_SHL_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_FIND_RD;
            end
         end
         ST_SHL_RD: begin
            if ((i_ff + 1'b1) < held_ff) begin
               state_in = ST_SHL_WR;
            end else begin
               held_in = held_ff - 1'b1;
               if (kind_ff == REQ_REMOVE) begin
                  state_in = ST_FIN;
               end else begin
                  i_in     = held_ff - 1'b1;
                  state_in = ST_INS_RD;
               end
            end
         end
         ST_SHL_WR: begin
            st_we    = 1'b1;
            i_in     = i_ff + 1'b1;
            state_in = ST_SHL_RD;
         end
         ST_INS_RD: begin
            if (i_ff == '0) begin
               st_we         = 1'b1;
               st_wdata.id   = id_ff;
               st_wdata.prio = np_ff;
               held_in       = held_ff + 1'b1;
               state_in      = ST_FIN;
            end else begin
               state_in = ST_INS_USE;
            end
         end
         ST_INS_USE: begin
            st_we = 1'b1;
            if (pred) begin
               i_in     = i_ff - 1'b1;
               state_in = ST_INS_RD;
            end else begin
               st_wdata.id   = id_ff;
               st_wdata.prio = np_ff;
               held_in       = held_ff + 1'b1;
               state_in      = ST_FIN;
            end
         end
         ST_HEAD: begin
            res_ok_in   = 1'b1;
            res_id_in   = st_rdata.id;
            res_prio_in = st_rdata.prio;
            present_in[st_rdata.id[IDW-1:0]] = 1'b0;
            i_in        = '0;
            state_in    = ST_SHL_RD;
         end
         ST_FIN: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || load_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         present_ff   <= '0;
         limit_ff     <= 7'd64;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      res_ok_ff   <= res_ok_in;
      res_id_ff   <= res_id_in;
      res_prio_ff <= res_prio_in;
      if (accept) begin
         kind_ff <= req_type;
         id_ff   <= req_item_id;
         np_ff   <= req_new_priority;
      end
      if (load_rsp) begin
         rsp_ok_ff   <= res_ok_ff;
         rsp_id_ff   <= res_id_ff;
         rsp_prio_ff <= res_prio_ff;
         rsp_cnt_ff  <= held_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_out_id       = rsp_id_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_entry_count  = rsp_cnt_ff;

`include "indexed_priority_queue_assert.svh"

   `IPQ_ASSERT_NOW(a_held_range, clock, reset, 1'b1, held_ff <= CNT_W'(IDN))
   `IPQ_ASSERT_NEXT(a_idle_count_stable, clock, reset, state_ff == ST_IDLE, $stable(held_ff))
   `IPQ_ASSERT_NOW(a_find_in_range, clock, reset, state_ff == ST_FIND_USE, i_ff < held_ff)
endmodule
`default_nettype wire

### src/ipq_ram.sv
`default_nettype none
module ipq_ram #(
   parameter int WIDTH = 38,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### src/ipq_cmp.sv
`default_nettype none
module ipq_cmp (
   input  logic signed [ipq_pkg::PRIO_W-1:0] a,
   input  logic signed [ipq_pkg::PRIO_W-1:0] b,
   output ipq_pkg::cmp_type                  res
);
   import ipq_pkg::*;

   // signed order matches Q16.16 priority order
   assign res.gt = (a > b);
   assign res.eq = (a == b);
endmodule
`default_nettype wire
